// ----- hdl/tbpl_pkg.sv -----
package tbpl_pkg;

    localparam int TBL_ENTRIES_DEF = 256;

    localparam int KEY_W   = 38;
    localparam int TOK_W   = 16;
    localparam int VIOL_W  = 8;
    localparam int TIME_W  = 31;
    localparam int BAN_W   = 32;
    localparam int B_ROW_W = KEY_W + TOK_W;
    localparam int P_ROW_W = KEY_W + VIOL_W + TIME_W + BAN_W;

    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_GLOBAL    = 2'd1;
    localparam logic [1:0] STAT_BANNED    = 2'd2;
    localparam logic [1:0] STAT_EXHAUSTED = 2'd3;

    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_WINDOW    = 2'd1;
    localparam logic [1:0] CFG_BAN       = 2'd2;
    localparam logic [1:0] CFG_REFILL    = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEN_SCAN,
        ST_BKT_SCAN,
        ST_VIO_SCAN,
        ST_VIO_UPD,
        ST_BSWEEP,
        ST_PSWEEP,
        ST_DONE
    } state_t;

endpackage

// ----- hdl/token_bucket_penalty_box_limiter_top.sv -----
// Token bucket rate limiter with a penalty box, keyed by {pid, service id}.
// Requests enter on the s_ channel (s_tuser carries the operation and the
// service-present flag, s_tdata the rest); each request gives exactly one
// result word on the m_ channel. The user must write the configuration
// registers through cfg_we/cfg_addr/cfg_wdata only while no request is in
// flight; the block itself does not enforce this. Both tables sit in
// single-port-read synchronous memories and are searched one entry per
// cycle. An unnamed caller is answered without a search; a check can scan
// the penalty table, the bucket table and the penalty table again, and a
// service reset sweeps both tables.
// One request is worked on at a time; a new request is taken as soon as the
// previous one has moved its result into the output register, even while
// that result still waits for m_tready. A stalled receiver holds the result
// and, once the next request is finished, holds that request in its final
// state until the output register frees.
// Reset empties both tables (the fill counts go to zero, memory contents are
// left as they are) and loads the registers with their default values.
module token_bucket_penalty_box_limiter_top
    import tbpl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TBL_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [21:0] requester_pid, [37:22] service_id, [38] global_limit_hit,
    // [54:39] capacity, [85:55] now_seconds, [87:86] zero
    input  logic [87:0] s_tdata,
    // [1:0] operation, [2] service_present
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [17:2] tokens_left, [18] is_banned, [23:19] zero
    output logic [23:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW:0] DEPTH = (AW+1)'(TABLE_ENTRIES);

    state_t state_reg, state_next;

    logic [1:0]        op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [TOK_W-1:0]  cap_reg, cap_next;
    logic [TIME_W-1:0] now_reg, now_next;

    logic [7:0]  thr_reg;
    logic [15:0] win_reg, bans_reg, refill_reg;

    logic [AW:0]   b_used_reg, b_used_next, p_used_reg, p_used_next;
    logic [AW:0]   sc_cnt_reg, sc_cnt_next;
    logic          sc_vld_reg, sc_vld_next;
    logic [AW-1:0] sc_addr_reg, sc_addr_next;

    logic              p_found_reg, p_found_next;
    logic [AW-1:0]     p_idx_reg, p_idx_next;
    logic [VIOL_W-1:0] p_viol_reg, p_viol_next;
    logic [TIME_W-1:0] p_ws_reg, p_ws_next;
    logic [BAN_W-1:0]  p_ban_reg, p_ban_next;

    logic [1:0]       res_status_reg, res_status_next;
    logic [TOK_W-1:0] res_tok_reg, res_tok_next;
    logic             res_ban_reg, res_ban_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [23:0] m_tdata_reg, m_tdata_next;

    logic [B_ROW_W-1:0] b_mem [TABLE_ENTRIES];
    logic [P_ROW_W-1:0] p_mem [TABLE_ENTRIES];
    logic [B_ROW_W-1:0] b_rd_reg, b_wdata;
    logic [P_ROW_W-1:0] p_rd_reg, p_wdata;
    logic               b_we, p_we;
    logic [AW-1:0]      b_waddr, p_waddr;

    logic [KEY_W-1:0]  b_rd_key, p_rd_key;
    logic [TOK_W-1:0]  b_rd_tok;
    logic [VIOL_W-1:0] p_rd_viol;
    logic [TIME_W-1:0] p_rd_ws;
    logic [BAN_W-1:0]  p_rd_ban;

    logic        pen_side, sc_more, sc_end, b_hit, p_hit, p_banned;
    logic [AW:0] used_sel;

    // Violation update terms.
    logic [AW-1:0]     v_idx;
    logic              v_can, v_restart, v_trip;
    logic [VIOL_W-1:0] v_viol0, v_viol1;
    logic [TIME_W-1:0] v_ws0, v_diff;
    logic [BAN_W-1:0]  v_ban0, v_ban_new;

    assign b_rd_key  = b_rd_reg[B_ROW_W-1 -: KEY_W];
    assign b_rd_tok  = b_rd_reg[TOK_W-1:0];
    assign p_rd_key  = p_rd_reg[P_ROW_W-1 -: KEY_W];
    assign p_rd_viol = p_rd_reg[BAN_W+TIME_W +: VIOL_W];
    assign p_rd_ws   = p_rd_reg[BAN_W +: TIME_W];
    assign p_rd_ban  = p_rd_reg[BAN_W-1:0];

    assign pen_side = (state_reg == ST_PEN_SCAN) || (state_reg == ST_VIO_SCAN)
                   || (state_reg == ST_PSWEEP);
    assign used_sel = pen_side ? p_used_reg : b_used_reg;
    assign sc_more  = sc_cnt_reg < used_sel;
    assign sc_end   = !sc_vld_reg && !sc_more;
    assign b_hit    = sc_vld_reg && (b_rd_key == key_reg);
    assign p_hit    = sc_vld_reg && (p_rd_key == key_reg);
    assign p_banned = p_hit && (p_rd_ban != '0) && ({1'b0, now_reg} < p_rd_ban);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk)
    begin
        if (sc_more)
        begin
            b_rd_reg <= b_mem[sc_cnt_reg[AW-1:0]];
            p_rd_reg <= p_mem[sc_cnt_reg[AW-1:0]];
        end
        if (b_we)
        begin
            b_mem[b_waddr] <= b_wdata;
        end
        if (p_we)
        begin
            p_mem[p_waddr] <= p_wdata;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (!s_tuser[2])
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        unique case (s_tuser[1:0])
                            OP_CHECK: state_next = s_tdata[38] ? ST_VIO_SCAN : ST_PEN_SCAN;
                            OP_SET:   state_next = ST_BKT_SCAN;
                            OP_RESET: state_next = ST_BSWEEP;
                            OP_QUERY: state_next = ST_BKT_SCAN;
                            default:  state_next = ST_DONE;
                        endcase
                    end
                end
            end
            ST_PEN_SCAN:
            begin
                if (p_hit || sc_end)
                begin
                    state_next = (op_reg == OP_QUERY || p_banned) ? ST_DONE : ST_BKT_SCAN;
                end
            end
            ST_BKT_SCAN:
            begin
                if (b_hit || sc_end)
                begin
                    if (op_reg == OP_CHECK && b_hit && b_rd_tok == '0)
                    begin
                        state_next = ST_VIO_SCAN;
                    end
                    else if (op_reg == OP_QUERY)
                    begin
                        state_next = ST_PEN_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_VIO_SCAN:
            begin
                if (p_hit || sc_end)
                begin
                    state_next = ST_VIO_UPD;
                end
            end
            ST_VIO_UPD: state_next = ST_DONE;
            ST_BSWEEP:
            begin
                if (sc_end)
                begin
                    state_next = ST_PSWEEP;
                end
            end
            ST_PSWEEP:
            begin
                if (sc_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Violation arithmetic on the entry held from the penalty search.
    always_comb
    begin
        v_can     = p_found_reg || (p_used_reg < DEPTH);
        v_idx     = p_found_reg ? p_idx_reg : p_used_reg[AW-1:0];
        v_viol0   = p_found_reg ? p_viol_reg : '0;
        v_ws0     = p_found_reg ? p_ws_reg : '0;
        v_ban0    = p_found_reg ? p_ban_reg : '0;
        v_diff    = now_reg - v_ws0;
        // A time that goes backwards keeps the current window.
        v_restart = (v_ws0 == '0) || ((now_reg > v_ws0) && (v_diff > {15'd0, win_reg}));
        v_viol1   = (v_restart ? '0 : v_viol0) + 8'd1;
        v_trip    = v_viol1 >= thr_reg;
        v_ban_new = {1'b0, now_reg} + {16'd0, bans_reg};
    end

    // Datapath and memory writes.
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        cap_next        = cap_reg;
        now_next        = now_reg;
        b_used_next     = b_used_reg;
        p_used_next     = p_used_reg;
        p_found_next    = p_found_reg;
        p_idx_next      = p_idx_reg;
        p_viol_next     = p_viol_reg;
        p_ws_next       = p_ws_reg;
        p_ban_next      = p_ban_reg;
        res_status_next = res_status_reg;
        res_tok_next    = res_tok_reg;
        res_ban_next    = res_ban_reg;
        b_we            = 1'b0;
        b_waddr         = sc_addr_reg;
        b_wdata         = {key_reg, cap_reg};
        p_we            = 1'b0;
        p_waddr         = sc_addr_reg;
        p_wdata         = {p_rd_key, {(P_ROW_W-KEY_W){1'b0}}};
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        if (state_next != state_reg)
        begin
            sc_cnt_next = '0;
            sc_vld_next = 1'b0;
        end
        else
        begin
            sc_vld_next = sc_more;
            sc_cnt_next = sc_more ? sc_cnt_reg + 1'b1 : sc_cnt_reg;
        end
        sc_addr_next = sc_cnt_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next         = s_tuser[1:0];
                    // The key holds the pid above the service id.
                    key_next        = {s_tdata[21:0], s_tdata[37:22]};
                    cap_next        = s_tdata[54:39];
                    now_next        = s_tdata[85:55];
                    res_status_next = (s_tuser[1:0] == OP_CHECK && s_tdata[38])
                                    ? STAT_GLOBAL : STAT_OK;
                    res_tok_next    = '0;
                    res_ban_next    = 1'b0;
                end
            end
            ST_PEN_SCAN:
            begin
                if (p_hit && p_rd_ban != '0 && !p_banned)
                begin
                    p_we = 1'b1;
                end
                if (p_banned)
                begin
                    res_ban_next = (op_reg == OP_QUERY);
                    if (op_reg == OP_CHECK)
                    begin
                        res_status_next = STAT_BANNED;
                    end
                end
            end
            ST_BKT_SCAN:
            begin
                if (b_hit)
                begin
                    b_waddr = sc_addr_reg;
                    if (op_reg == OP_CHECK)
                    begin
                        if (b_rd_tok == '0)
                        begin
                            res_status_next = STAT_EXHAUSTED;
                        end
                        else
                        begin
                            b_we    = 1'b1;
                            b_wdata = {key_reg, b_rd_tok - 16'd1};
                        end
                    end
                    else if (op_reg == OP_SET)
                    begin
                        b_we = 1'b1;
                    end
                    else if (op_reg == OP_QUERY)
                    begin
                        res_tok_next = b_rd_tok;
                    end
                end
                else if (sc_end && op_reg == OP_SET && b_used_reg < DEPTH)
                begin
                    b_we        = 1'b1;
                    b_waddr     = b_used_reg[AW-1:0];
                    b_used_next = b_used_reg + 1'b1;
                end
            end
            ST_VIO_SCAN:
            begin
                p_found_next = p_hit;
                p_idx_next   = sc_addr_reg;
                p_viol_next  = p_rd_viol;
                p_ws_next    = p_rd_ws;
                p_ban_next   = p_rd_ban;
            end
            ST_VIO_UPD:
            begin
                p_we    = v_can;
                p_waddr = v_idx;
                if (v_trip)
                begin
                    p_wdata = {key_reg, {VIOL_W{1'b0}}, {TIME_W{1'b0}}, v_ban_new};
                end
                else
                begin
                    p_wdata = {key_reg, v_viol1, v_restart ? now_reg : v_ws0, v_ban0};
                end
                if (!p_found_reg && v_can)
                begin
                    p_used_next = p_used_reg + 1'b1;
                end
            end
            ST_BSWEEP:
            begin
                if (sc_vld_reg && b_rd_key[15:0] == key_reg[15:0])
                begin
                    b_we    = 1'b1;
                    b_wdata = {b_rd_key, refill_reg};
                end
            end
            ST_PSWEEP:
            begin
                if (sc_vld_reg && p_rd_key[15:0] == key_reg[15:0])
                begin
                    p_we = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, res_ban_reg, res_tok_reg, res_status_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            b_used_reg   <= '0;
            p_used_reg   <= '0;
            sc_cnt_reg   <= '0;
            sc_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            thr_reg      <= 8'd5;
            win_reg      <= 16'd10;
            bans_reg     <= 16'd60;
            refill_reg   <= 16'd10;
        end
        else
        begin
            state_reg    <= state_next;
            b_used_reg   <= b_used_next;
            p_used_reg   <= p_used_next;
            sc_cnt_reg   <= sc_cnt_next;
            sc_vld_reg   <= sc_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_THRESHOLD: thr_reg    <= cfg_wdata[7:0];
                    CFG_WINDOW:    win_reg    <= cfg_wdata;
                    CFG_BAN:       bans_reg   <= cfg_wdata;
                    CFG_REFILL:    refill_reg <= cfg_wdata;
                    default:       thr_reg    <= thr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        cap_reg        <= cap_next;
        now_reg        <= now_next;
        sc_addr_reg    <= sc_addr_next;
        p_found_reg    <= p_found_next;
        p_idx_reg      <= p_idx_next;
        p_viol_reg     <= p_viol_next;
        p_ws_reg       <= p_ws_next;
        p_ban_reg      <= p_ban_next;
        res_status_reg <= res_status_next;
        res_tok_reg    <= res_tok_next;
        res_ban_reg    <= res_ban_next;
        m_tdata_reg    <= m_tdata_next;
    end

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (b_used_reg <= DEPTH) && (p_used_reg <= DEPTH))
        else $error("table fill count beyond depth");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (b_used_reg == $past(b_used_reg) || b_used_reg == $past(b_used_reg) + 1'b1)
              && (p_used_reg == $past(p_used_reg) || p_used_reg == $past(p_used_reg) + 1'b1))
        else $error("table fill count moved by more than one");

    a_deny_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && m_tdata_reg[1:0] != STAT_OK |-> m_tdata_reg[18:2] == '0)
        else $error("denied result carries query fields");

endmodule
